>>> src/esc_pkg.sv
package esc_pkg;

    localparam int IN_W    = 33;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic signed [IN_W-1:0] T_MIN = -33'sd2177452800;
    localparam logic signed [IN_W-1:0] T_MAX = 33'sd4102444799;

    localparam int REM_W     = 17;
    localparam int DAYS_W    = 17;
    localparam int CYC_W     = 6;
    localparam int DOY_W     = 11;
    localparam int HREM_W    = 12;

    // reciprocal divider: floor(x / d) = (x * ceil(2^s / d)) >> s over each operand range
    localparam int OPND_W  = 26;
    localparam int RECIP_W = 27;
    localparam int PROD_W  = 53;
    localparam int QUO_W   = 17;
    localparam int DIVR_W  = 12;
    localparam int CNT_W   = 2;
    localparam int DAY_LSB = 7;

    localparam logic [CNT_W-1:0] STEP_MUL = 2'd0;
    localparam logic [CNT_W-1:0] STEP_QUO = 2'd1;
    localparam logic [CNT_W-1:0] STEP_REM = 2'd2;

    // seconds per day over 128, the low 7 bits pass straight to the remainder
    localparam logic [DIVR_W-1:0] SECS_PER_DAY_HI = 12'd675;
    localparam logic [DIVR_W-1:0] DAYS_PER_CYCLE  = 12'd1461;
    localparam logic [DIVR_W-1:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [DIVR_W-1:0] SECS_PER_MIN    = 12'd60;

    localparam logic [RECIP_W-1:0] RECIP_DAY  = 27'd101806633;
    localparam logic [RECIP_W-1:0] RECIP_CYC  = 27'd183735;
    localparam logic [RECIP_W-1:0] RECIP_HOUR = 27'd149131;
    localparam logic [RECIP_W-1:0] RECIP_MIN  = 27'd4370;

    localparam int SHIFT_DAY  = 36;
    localparam int SHIFT_CYC  = 28;
    localparam int SHIFT_HOUR = 29;
    localparam int SHIFT_MIN  = 18;

    localparam logic [DOY_W-1:0] DAYS_PER_YEAR  = 11'd365;
    localparam logic [YEAR_W-1:0] BASE_YEAR     = 12'd1901;
    localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_CYC,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_START,
        ST_DAY_RUN,
        ST_CYC_START,
        ST_CYC_RUN,
        ST_YEAR,
        ST_HOUR_START,
        ST_HOUR_RUN,
        ST_MIN_START,
        ST_MIN_RUN,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     in_load;
        logic     div_start;
        logic     div_step;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic year_done;
        logic month_done;
    } dp_status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> src/esc_ctrl.sv
module esc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  esc_pkg::dp_status_t status,
    output esc_pkg::ctrl_cmd_t  cmd
);
    import esc_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_DAY_START;
            ST_DAY_START:  state_next = ST_DAY_RUN;
            ST_DAY_RUN:    if (status.div_last) state_next = ST_CYC_START;
            ST_CYC_START:  state_next = ST_CYC_RUN;
            ST_CYC_RUN:    if (status.div_last) state_next = ST_YEAR;
            ST_YEAR:       if (status.year_done) state_next = ST_HOUR_START;
            ST_HOUR_START: state_next = ST_HOUR_RUN;
            ST_HOUR_RUN:   if (status.div_last) state_next = ST_MIN_START;
            ST_MIN_START:  state_next = ST_MIN_RUN;
            ST_MIN_RUN:    if (status.div_last) state_next = ST_MONTH;
            ST_MONTH:      if (status.month_done) state_next = ST_FINISH;
            ST_FINISH:     if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd           = '0;
        cmd.div_sel   = DIV_DAY;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            ST_DAY_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DAY;
            end
            ST_CYC_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CYC;
            end
            ST_HOUR_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_HOUR;
            end
            ST_MIN_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MIN;
            end
            ST_DAY_RUN, ST_CYC_RUN, ST_HOUR_RUN, ST_MIN_RUN: begin
                cmd.div_step = 1'b1;
            end
            ST_YEAR: begin
                cmd.year_step = !status.year_done;
            end
            ST_MONTH: begin
                cmd.month_step = !status.month_done;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> src/esc_datapath.sv
module esc_datapath (
    input  logic                               aclk,
    input  logic [esc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  esc_pkg::ctrl_cmd_t                 cmd,
    output esc_pkg::dp_status_t                status,
    output logic [esc_pkg::M_TDATA_W-1:0]      m_tdata
);
    import esc_pkg::*;

    logic signed [IN_W-1:0] in_val;
    logic signed [IN_W-1:0] in_reg;
    logic [IN_W-1:0]        u;

    // shared reciprocal-multiply divider
    logic [OPND_W-1:0]  x_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QUO_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg;
    div_sel_t           sel_reg;
    logic [DIVR_W-1:0]  divisor;
    logic [RECIP_W-1:0] recip;
    logic [OPND_W-1:0]  qd;
    logic [OPND_W-1:0]  rem;
    logic [OPND_W-1:0]  dividend;

    logic [DAYS_W-1:0]   days_reg;
    logic [REM_W-1:0]    sod_reg;
    logic [CYC_W-1:0]    cyc_reg;
    logic [DOY_W-1:0]    doy_reg;
    logic [1:0]          yi_reg;
    logic [HREM_W-1:0]   hrem_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    len;
    logic                leap;
    logic                div_last;

    logic [YEAR_W-1:0]    year_val;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign in_val = s_tdata[IN_W-1:0];
    assign u      = in_reg - T_MIN;

    always_comb begin
        unique case (sel_reg)
            DIV_DAY: begin
                divisor = SECS_PER_DAY_HI;
                recip   = RECIP_DAY;
                q_next  = prod_reg[SHIFT_DAY +: QUO_W];
            end
            DIV_CYC: begin
                divisor = DAYS_PER_CYCLE;
                recip   = RECIP_CYC;
                q_next  = prod_reg[SHIFT_CYC +: QUO_W];
            end
            DIV_HOUR: begin
                divisor = SECS_PER_HOUR;
                recip   = RECIP_HOUR;
                q_next  = prod_reg[SHIFT_HOUR +: QUO_W];
            end
            DIV_MIN: begin
                divisor = SECS_PER_MIN;
                recip   = RECIP_MIN;
                q_next  = prod_reg[SHIFT_MIN +: QUO_W];
            end
            default: begin
                divisor = SECS_PER_DAY_HI;
                recip   = RECIP_DAY;
                q_next  = prod_reg[SHIFT_DAY +: QUO_W];
            end
        endcase
    end

    always_comb begin
        unique case (cmd.div_sel)
            DIV_DAY:  dividend = u[IN_W-1:DAY_LSB];
            DIV_CYC:  dividend = {{(OPND_W-DAYS_W){1'b0}}, days_reg};
            DIV_HOUR: dividend = {{(OPND_W-REM_W){1'b0}}, sod_reg};
            DIV_MIN:  dividend = {{(OPND_W-HREM_W){1'b0}}, hrem_reg};
            default:  dividend = u[IN_W-1:DAY_LSB];
        endcase
    end

    assign qd  = {{(OPND_W-QUO_W){1'b0}}, q_reg} * {{(OPND_W-DIVR_W){1'b0}}, divisor};
    assign rem = x_reg - qd;

    assign div_last = (cnt_reg == STEP_REM);
    assign leap     = (yi_reg == 2'd3);
    assign len      = month_len(month_reg, leap);

    assign status.div_last   = div_last;
    assign status.year_done  = (yi_reg == 2'd3) || (doy_reg < DAYS_PER_YEAR);
    assign status.month_done = (month_reg == LAST_MONTH) ||
                               (doy_reg < {{(DOY_W-DAY_W){1'b0}}, len});

    assign year_val = BASE_YEAR + {{(YEAR_W-CYC_W-2){1'b0}}, cyc_reg, 2'b00}
                    + {{(YEAR_W-2){1'b0}}, yi_reg};

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            if (in_val < T_MIN) begin
                in_reg <= T_MIN;
            end else if (in_val > T_MAX) begin
                in_reg <= T_MAX;
            end else begin
                in_reg <= in_val;
            end
        end

        if (cmd.div_start) begin
            x_reg   <= dividend;
            cnt_reg <= '0;
            sel_reg <= cmd.div_sel;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == STEP_MUL) begin
                prod_reg <= {{(PROD_W-OPND_W){1'b0}}, x_reg} *
                            {{(PROD_W-RECIP_W){1'b0}}, recip};
            end
            if (cnt_reg == STEP_QUO) begin
                q_reg <= q_next;
            end
            if (div_last) begin
                unique case (sel_reg)
                    DIV_DAY: begin
                        days_reg <= q_reg[DAYS_W-1:0];
                        sod_reg  <= {rem[REM_W-DAY_LSB-1:0], u[DAY_LSB-1:0]};
                    end
                    DIV_CYC: begin
                        cyc_reg   <= q_reg[CYC_W-1:0];
                        doy_reg   <= rem[DOY_W-1:0];
                        yi_reg    <= 2'd0;
                        month_reg <= '0;
                    end
                    DIV_HOUR: begin
                        hour_reg <= q_reg[HOUR_W-1:0];
                        hrem_reg <= rem[HREM_W-1:0];
                    end
                    DIV_MIN: begin
                        minute_reg <= q_reg[MINUTE_W-1:0];
                        second_reg <= rem[SECOND_W-1:0];
                    end
                    default: begin
                        days_reg <= q_reg[DAYS_W-1:0];
                    end
                endcase
            end
        end

        if (cmd.year_step) begin
            doy_reg <= doy_reg - DAYS_PER_YEAR;
            yi_reg  <= yi_reg + 2'd1;
        end

        if (cmd.month_step) begin
            doy_reg   <= doy_reg - {{(DOY_W-DAY_W){1'b0}}, len};
            month_reg <= month_reg + 4'd1;
        end

        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00,
                            second_reg,
                            minute_reg,
                            hour_reg,
                            doy_reg[DAY_W-1:0] + 5'd1,
                            month_reg + 4'd1,
                            year_val};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

>>> src/epoch_seconds_to_civil_date.sv
// channel | dir | ports                     | transaction
// s_      | in  | s_tvalid s_tready s_tdata | epoch seconds, signed
// m_      | out | m_tvalid m_tready m_tdata | year month day hour minute second
//
// one transaction in flight; the next input is accepted only once the result
// is loaded, after four passes of a shared reciprocal-multiply divider, the
// year steps and the month steps
// aresetn is synchronous; it clears the controller and the output valid
// a held result does not stop the next input, only the final output load
module epoch_seconds_to_civil_date (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [esc_pkg::S_TDATA_W-1:0] s_tdata,  // [32:0] epoch_seconds
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
    // [31:26] minute, [37:32] second
    output logic [esc_pkg::M_TDATA_W-1:0] m_tdata
);
    import esc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    esc_datapath u_dp (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

>>> src/esc_checker.sv
module esc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:0] >= 12'd1901) && (m_tdata[11:0] <= 12'd2099)
                  && (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12)
                  && (m_tdata[20:16] >= 5'd1))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59)
                  && (m_tdata[37:32] <= 6'd59) && (m_tdata[39:38] == 2'b00))
        else $error("time field out of range");

endmodule

bind epoch_seconds_to_civil_date esc_checker u_esc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_epoch_seconds_to_civil_date.sv
module tb_epoch_seconds_to_civil_date;

    import esc_pkg::*;

    localparam int         IDLE_LIMIT   = 2000;
    localparam int         TAIL_CYCLES  = 200;
    localparam int         MAX_REPORTS  = 10;
    localparam int         RANDOM_ITEMS = 1230;
    localparam longint     DAY_SECS     = 86400;
    localparam longint     CYCLE_DAYS   = 1461;
    localparam longint     YEAR_DAYS    = 365;
    localparam longint     SPAN_DAYS    = 72684;
    localparam longint     FIRST_SEC    = longint'(T_MIN);
    localparam longint     LAST_SEC     = longint'(T_MAX);

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } civil_date_t;

    class civil_date_board;
        civil_date_t pending_dates[$];
        int          mismatches = 0;

        function civil_date_t civil_date_of(logic signed [IN_W-1:0] t);
            longint      secs, offset, days, sod, rem, yi, doy, year;
            int          mon, mlen;
            bit          leap;
            civil_date_t d;
            secs = t;
            if (secs < FIRST_SEC) secs = FIRST_SEC;
            if (secs > LAST_SEC) secs = LAST_SEC;
            offset = secs - FIRST_SEC;
            days   = offset / DAY_SECS;
            sod    = offset % DAY_SECS;
            rem    = days % CYCLE_DAYS;
            yi     = rem / YEAR_DAYS;
            if (yi > 3) yi = 3;
            doy  = rem - YEAR_DAYS * yi;
            year = 1901 + 4 * (days / CYCLE_DAYS) + yi;
            leap = (year % 4) == 0;
            mon  = 0;
            while (mon < 11) begin
                if (mon == 1) mlen = leap ? 29 : 28;
                else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) mlen = 30;
                else mlen = 31;
                if (doy < mlen) break;
                doy -= mlen;
                mon++;
            end
            d.year   = YEAR_W'(year);
            d.month  = MONTH_W'(mon + 1);
            d.day    = DAY_W'(doy + 1);
            d.hour   = HOUR_W'(sod / 3600);
            d.minute = MINUTE_W'((sod % 3600) / 60);
            d.second = SECOND_W'(sod % 60);
            return d;
        endfunction

        function void note_input(logic signed [IN_W-1:0] t);
            pending_dates.push_back(civil_date_of(t));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            civil_date_t want, got;
            got.year   = word[11:0];
            got.month  = word[15:12];
            got.day    = word[20:16];
            got.hour   = word[25:21];
            got.minute = word[31:26];
            got.second = word[37:32];
            if (pending_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year,
                             got.month, got.day, got.hour, got.minute, got.second);
                return;
            end
            want = pending_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month ||
                got.day !== want.day || got.hour !== want.hour ||
                got.minute !== want.minute || got.second !== want.second) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                             want.year, want.month, want.day, want.hour, want.minute,
                             want.second, got.year, got.month, got.day, got.hour,
                             got.minute, got.second);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    civil_date_board board;
    bit              quiet = 1'b0;
    int              idle_cycles = 0;

    epoch_seconds_to_civil_date uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic send_seconds(input longint secs);
        int                     gap;
        logic signed [IN_W-1:0] t;
        t   = IN_W'(secs);
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-IN_W){1'b0}}, t};
        do @(posedge aclk); while (!s_tready);
        board.note_input(t);
    endtask

    function automatic longint random_seconds();
        longint unsigned wide;
        longint          secs;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            wide = {$urandom, $urandom};
            secs = FIRST_SEC + longint'(wide % longint'(SPAN_DAYS * DAY_SECS));
        end else if (pick < 8) begin
            secs = FIRST_SEC + longint'($urandom_range(0, SPAN_DAYS - 1)) * DAY_SECS;
            case ($urandom_range(0, 2))
                0:       secs = secs;
                1:       secs = secs + DAY_SECS - 1;
                default: secs = secs + longint'($urandom_range(0, DAY_SECS - 1));
            endcase
        end else if (pick == 8) begin
            secs = longint'($signed({1'($urandom_range(0, 1)), 32'($urandom)}));
        end else begin
            secs = ($urandom_range(0, 1) ? LAST_SEC : FIRST_SEC)
                   + longint'($urandom_range(0, 10)) - 5;
        end
        return secs;
    endfunction

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (gap - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    initial begin
        longint directed_secs[$];
        board = new;
        directed_secs = '{
            -64'sd4294967296, 64'sd4294967295, -64'sd2177452801, -64'sd2177452800,
            -64'sd2145916801, 64'sd4102444799, 64'sd4102444800, 64'sd4102358400,
            -64'sd1, 64'sd0, 64'sd1, 64'sd86399, 64'sd86400, -64'sd86400,
            -64'sd86401, -64'sd31622400, -64'sd31536001, 64'sd951782400,
            64'sd951868800, 64'sd978220800, 64'sd978307199, 64'sd2147483647,
            64'sd2147483648, -64'sd2147483648, 64'sd4078137600
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_secs[i]) send_seconds(directed_secs[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500 && n < 650);
            send_seconds(random_seconds());
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (board.pending_dates.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_dates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/esc_pkg.sv
src/esc_ctrl.sv
src/esc_datapath.sv
src/epoch_seconds_to_civil_date.sv
src/esc_checker.sv
tb/tb_epoch_seconds_to_civil_date.sv
